>>> hdl/tcpu16_pkg.sv
// Shared types, opcodes and constants of the toy 16-bit execute step.
package tcpu16_pkg;

    // Instruction opcodes, upper nibble of the instruction word
    typedef enum logic [3:0] {
        OP_MOV   = 4'd0,
        OP_NOT   = 4'd1,
        OP_AND   = 4'd2,
        OP_OR    = 4'd3,
        OP_ADD   = 4'd4,
        OP_SUB   = 4'd5,
        OP_ADDI  = 4'd6,
        OP_SUBI  = 4'd7,
        OP_SETLO = 4'd8,
        OP_SETHI = 4'd9,
        OP_ADDZ  = 4'd10,
        OP_SUBN  = 4'd11,
        OP_MOVZ  = 4'd12,
        OP_MOVNZ = 4'd13,
        OP_MOVP  = 4'd14,
        OP_MOVN  = 4'd15
    } t_opcode;

    // Register roles
    localparam logic [3:0] REG_IN       = 4'd6;
    localparam logic [3:0] REG_OUT_DATA = 4'd13;
    localparam logic [3:0] REG_OUT_ADDR = 4'd14;
    localparam logic [3:0] REG_PC       = 4'd15;

    // Control bits of the output data register
    localparam int STORE_BIT  = 15;
    localparam int SCREEN_BIT = 14;

    localparam logic [15:0] PC_LIMIT_RESET = 16'hFFFE;
    localparam int          RAM_DEPTH_DEF  = 65536;

    // Operands handed to the execute unit
    typedef struct packed {
        t_opcode     op;
        logic [3:0]  imm_a;
        logic [3:0]  imm_b;
        logic [15:0] opnd_x;   // R[a], or R[dest] for the read-modify forms
        logic [15:0] opnd_y;   // R[b]
    } t_alu_req;

    // Execute unit answer
    typedef struct packed {
        logic        took;
        logic [15:0] value;
    } t_alu_res;

endpackage

>>> hdl/tcpu16_alu.sv
// Execute unit: opcode decode, arithmetic and condition evaluation.
module tcpu16_alu
    import tcpu16_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_res o_res
);

    logic [7:0]  byte_imm;
    logic [15:0] x;
    logic [15:0] y;

    assign byte_imm = {i_req.imm_a, i_req.imm_b};
    assign x        = i_req.opnd_x;
    assign y        = i_req.opnd_y;

    // Compute the result value and whether the write takes effect
    always_comb begin
        o_res.took  = 1'b1;
        o_res.value = x;
        case (i_req.op)
            OP_MOV:   o_res.value = x;
            OP_NOT:   o_res.value = ~x;
            OP_AND:   o_res.value = x & y;
            OP_OR:    o_res.value = x | y;
            OP_ADD:   o_res.value = x + y;
            OP_SUB:   o_res.value = x - y;
            OP_ADDI:  o_res.value = x + 16'(i_req.imm_b);
            OP_SUBI:  o_res.value = x - 16'(i_req.imm_b);
            OP_SETLO: o_res.value = 16'(byte_imm);
            OP_SETHI: o_res.value = {byte_imm, x[7:0]};
            OP_ADDZ: begin
                o_res.took  = (y == 16'd0);
                o_res.value = x + 16'(i_req.imm_a);
            end
            OP_SUBN: begin
                o_res.took  = y[15];
                o_res.value = x - 16'(i_req.imm_a);
            end
            OP_MOVZ:  o_res.took = (y == 16'd0);
            OP_MOVNZ: o_res.took = (y != 16'd0);
            OP_MOVP:  o_res.took = ~y[15];
            OP_MOVN:  o_res.took = y[15];
            default: begin
                o_res.took  = 1'b1;
                o_res.value = x;
            end
        endcase
    end

endmodule

>>> hdl/toy_cpu16_execute_step.sv
// Top level: one instruction per beat on a 16-entry register file with data RAM and screen.
//
// Input channel: i_valid / o_ready carry one instruction word per beat.
// Output channel: o_valid / i_ready carry one result per instruction: next PC,
// halt status and the byte stored by that instruction, if any.
// Configuration: i_cfg_we writes i_cfg_wdata into the PC limit; write it only
// while no instruction is in flight.
// Pipeline: an accepted instruction is latched into the operand stage, executes
// there once the result register can take it, and its result is captured in
// the result register, which drives o_valid.
// Throughput: one instruction per cycle while i_ready is high and the RAM is not
// being cleared; the data RAM is read with the next R14 value as each instruction
// commits, so the input-register preload of the following instruction is ready in time.
// Reset: registers, screen and halt flag clear at once; the data RAM is then
// zeroed one byte per cycle, every address in turn, with o_ready held low.
// Stall: while i_ready is low the result register holds, the operand stage
// keeps its instruction and o_ready drops once both are full.
// After the PC reaches the limit every instruction returns the PC unchanged
// with the halted flag set until the next reset.
module toy_cpu16_execute_step
    import tcpu16_pkg::*;
#(
    parameter int RAM_DEPTH = RAM_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // instruction channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_instruction,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_next_pc,
    output logic        o_halted,
    output logic        o_store_valid,
    output logic        o_store_to_screen,
    output logic [15:0] o_store_address,
    output logic [7:0]  o_store_data
);

    localparam int  RamAw   = $clog2(RAM_DEPTH);
    localparam bit  RamPow2 = ((RAM_DEPTH & (RAM_DEPTH - 1)) == 0);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [15:0]      r_reg [16];
    logic [15:0]      n_reg [16];
    logic [7:0]       r_screen [16];
    logic [7:0]       r_ram [RAM_DEPTH];
    logic [7:0]       r_rd_data;
    logic             r_halt;
    logic             n_halt;
    logic [15:0]      r_pc_limit;
    logic             r_clearing;
    logic [RamAw-1:0] r_clr_addr;

    // operand stage
    logic             r_in_valid;
    t_opcode          r_op;
    logic [3:0]       r_dst;
    logic [3:0]       r_ia;
    logic [3:0]       r_ib;
    logic [3:0]       r_idx1;
    logic [15:0]      r_opnd1;
    logic [15:0]      r_opnd2;

    // result register
    logic             r_out_valid;
    logic [15:0]      r_out_next_pc;
    logic             r_out_halted;
    logic             r_out_store_valid;
    logic             r_out_store_to_screen;
    logic [15:0]      r_out_store_address;
    logic [7:0]       r_out_store_data;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic exec;
    logic accept;

    assign exec    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_clearing && (!r_in_valid || exec);
    assign accept  = i_valid && o_ready;

    // ------------------------------------------------------------------
    // Operand fetch at accept, forwarded from the committing instruction
    // ------------------------------------------------------------------
    t_opcode    in_op;
    logic [3:0] in_idx1;

    assign in_op   = t_opcode'(i_instruction[15:12]);
    assign in_idx1 = (in_op == OP_SETHI || in_op == OP_ADDZ || in_op == OP_SUBN)
                     ? i_instruction[11:8] : i_instruction[7:4];

    // Latch the instruction and its operands
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= in_op;
            r_dst   <= i_instruction[11:8];
            r_ia    <= i_instruction[7:4];
            r_ib    <= i_instruction[3:0];
            r_idx1  <= in_idx1;
            r_opnd1 <= n_reg[in_idx1];
            r_opnd2 <= n_reg[i_instruction[3:0]];
        end
    end

    // Track operand stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (exec) begin
            r_in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Execute
    // ------------------------------------------------------------------
    logic        halt_pre;
    logic        preload;
    logic [7:0]  load_byte;
    logic [15:0] r6_pre;
    t_alu_req    alu_req;
    t_alu_res    alu_res;
    logic        wr_dst;
    logic        inc_pc;

    assign halt_pre  = r_halt || (r_reg[REG_PC] >= r_pc_limit);
    assign preload   = !r_reg[REG_OUT_DATA][STORE_BIT];
    assign load_byte = r_reg[REG_OUT_DATA][SCREEN_BIT]
                       ? r_screen[r_reg[REG_OUT_ADDR][3:0]] : r_rd_data;
    assign r6_pre    = preload ? {r_reg[REG_IN][15:8], load_byte} : r_reg[REG_IN];

    // Substitute the preloaded input register where an operand names it
    assign alu_req.op     = r_op;
    assign alu_req.imm_a  = r_ia;
    assign alu_req.imm_b  = r_ib;
    assign alu_req.opnd_x = (r_idx1 == REG_IN) ? r6_pre : r_opnd1;
    assign alu_req.opnd_y = (r_ib == REG_IN) ? r6_pre : r_opnd2;

    tcpu16_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    assign wr_dst = alu_res.took && (r_dst != REG_IN);
    assign inc_pc = !wr_dst || (r_dst != REG_PC);

    // Next register file: preload, PC advance, destination write
    always_comb begin
        n_reg = r_reg;
        if (exec && !halt_pre) begin
            n_reg[REG_IN] = r6_pre;
            if (inc_pc) begin
                n_reg[REG_PC] = r_reg[REG_PC] + 16'd1;
            end
            if (wr_dst) begin
                n_reg[r_dst] = alu_res.value;
            end
        end
    end

    // ------------------------------------------------------------------
    // RAM index: R14 modulo the RAM depth
    // ------------------------------------------------------------------
    logic [15:0]      n_r14;
    logic [RamAw-1:0] ram_idx;

    assign n_r14 = n_reg[REG_OUT_ADDR];

    generate
        if (RamPow2) begin : g_mask
            assign ram_idx = n_r14[RamAw-1:0];
        end else begin : g_recip
            // floor(x / depth) by reciprocal multiply, exact for 16-bit x when depth is at least 256
            localparam int          WrapShift = 16 + RamAw;
            localparam logic [17:0] WrapMul   =
                18'((64'd1 << WrapShift) / RAM_DEPTH + 1);
            logic [33:0] prod;
            logic [7:0]  quot;
            logic [23:0] rem;
            assign prod    = 34'(n_r14) * 34'(WrapMul);
            assign quot    = 8'(prod >> WrapShift);
            assign rem     = 24'(n_r14) - 24'(quot) * 24'(RAM_DEPTH);
            assign ram_idx = rem[RamAw-1:0];
        end
    endgenerate

    // ------------------------------------------------------------------
    // Store write-back
    // ------------------------------------------------------------------
    logic st_en;
    logic st_screen;

    assign st_en     = exec && !halt_pre && n_reg[REG_OUT_DATA][STORE_BIT];
    assign st_screen = n_reg[REG_OUT_DATA][SCREEN_BIT];

    // Halt after the step that reaches the limit
    always_comb begin
        n_halt = r_halt;
        if (exec) begin
            n_halt = halt_pre || (n_reg[REG_PC] >= r_pc_limit);
        end
    end

    // Data RAM: clearing sweep or store, read with the next R14
    logic             ram_we;
    logic [RamAw-1:0] ram_wa;
    logic [7:0]       ram_wd;

    assign ram_we = r_clearing || (st_en && !st_screen);
    assign ram_wa = r_clearing ? r_clr_addr : ram_idx;
    assign ram_wd = r_clearing ? 8'd0 : n_reg[REG_OUT_DATA][7:0];

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_ram[ram_wa] <= ram_wd;
        end
        r_rd_data <= r_ram[ram_idx];
    end

    // Advance the clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + RamAw'(1);
            if (r_clr_addr == RamAw'(RAM_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Register file, screen, halt flag and PC limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg      <= '{default: '0};
            r_screen   <= '{default: '0};
            r_halt     <= 1'b0;
            r_pc_limit <= PC_LIMIT_RESET;
        end else begin
            r_reg  <= n_reg;
            r_halt <= n_halt;
            if (st_en && st_screen) begin
                r_screen[n_r14[3:0]] <= n_reg[REG_OUT_DATA][7:0];
            end
            if (i_cfg_we) begin
                r_pc_limit <= i_cfg_wdata;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture the beat payload
    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out_next_pc         <= halt_pre ? r_reg[REG_PC] : n_reg[REG_PC];
            r_out_halted          <= n_halt;
            r_out_store_valid     <= st_en;
            r_out_store_to_screen <= st_en && st_screen;
            if (!st_en) begin
                r_out_store_address <= 16'd0;
            end else if (st_screen) begin
                r_out_store_address <= {12'd0, n_r14[3:0]};
            end else begin
                r_out_store_address <= 16'(ram_idx);
            end
            r_out_store_data      <= st_en ? n_reg[REG_OUT_DATA][7:0] : 8'd0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_next_pc         = r_out_next_pc;
    assign o_halted          = r_out_halted;
    assign o_store_valid     = r_out_store_valid;
    assign o_store_to_screen = r_out_store_to_screen;
    assign o_store_address   = r_out_store_address;
    assign o_store_data      = r_out_store_data;

endmodule
